// ===== rtl/srm_pkg.sv =====
// shared types and constants for the shard result merge table
// no dependencies

package srm_pkg;

    localparam int KEY_W      = 64;
    localparam int SEQ_W      = 64;
    localparam int PAY_W      = 64;
    localparam int NODE_W     = 4;
    localparam int NODE_SLOTS = 1 << NODE_W;
    localparam int DIR_W      = 2;
    localparam int CNT_W      = 5;
    localparam int STATUS_W   = 2;

    localparam int IN_DATA_W  = 200;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 192;
    localparam int OUT_USER_W = 3;

    localparam logic [STATUS_W-1:0] ST_PENDING = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    localparam logic [DIR_W-1:0] DIR_PREV = 2'd0;

    typedef enum logic [1:0] {
        K_HIT,
        K_NEW,
        K_FULL
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   key;
        logic [NODE_W-1:0]  node;
        logic               found;
        logic [SEQ_W-1:0]   seqnum;
        logic [DIR_W-1:0]   dir;
        logic [PAY_W-1:0]   payload;
    } t_job;

    typedef struct packed {
        logic                  found;
        logic [SEQ_W-1:0]      seqnum;
        logic [DIR_W-1:0]      dir;
        logic [PAY_W-1:0]      payload;
        logic [NODE_SLOTS-1:0] nodes;
        logic [CNT_W-1:0]      cnt;
    } t_ans;

    typedef struct packed {
        logic done;
        logic free;
    } t_done;

endpackage

// ===== rtl/srm_queue.sv =====
// two-entry job queue between front and back
// depends on nothing but its width parameter

module srm_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/srm_front.sv =====
// front: accepts answers, matches keys against open entries, allocates slots
// depends on srm_pkg

module srm_front #(
    parameter  int TABLE_ENTRIES = 16,
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int QW = IW + $bits(srm_pkg::t_job)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [srm_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  logic [srm_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output logic [QW-1:0]                   o_q_data,
    input  srm_pkg::t_done                  i_done
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_MATCH,
        F_PUSH,
        F_WAIT
    } t_fstate;

    t_fstate                    r_state;
    logic                       r_valid [TABLE_ENTRIES];
    logic [srm_pkg::KEY_W-1:0]  r_key   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]   r_hit_vec;
    logic [TABLE_ENTRIES-1:0]   r_free_vec;
    srm_pkg::t_job              r_item;
    logic [IW-1:0]              r_idx;

    logic          hit_any;
    logic          free_any;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] free_idx;
    logic [IW-1:0] n_idx;
    srm_pkg::t_job job;

    // lowest matching and lowest free entry
    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_hit_vec[i]) begin
                hit_any = 1'b1;
                hit_idx = IW'(i);
            end
            if (r_free_vec[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        job = r_item;
        if (hit_any) begin
            job.kind = srm_pkg::K_HIT;
            n_idx    = hit_idx;
        end else if (free_any) begin
            job.kind = srm_pkg::K_NEW;
            n_idx    = free_idx;
        end else begin
            job.kind = srm_pkg::K_FULL;
            n_idx    = '0;
        end
    end

    assign o_s_axis_tready = (r_state == F_IDLE);
    assign o_q_push        = (r_state == F_PUSH) && !i_q_full;
    assign o_q_data        = {n_idx, job};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_state <= F_MATCH;
                    end
                end
                F_MATCH: begin
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        if (job.kind == srm_pkg::K_FULL) begin
                            r_state <= F_IDLE;
                        end else begin
                            r_state <= F_WAIT;
                        end
                        if (job.kind == srm_pkg::K_NEW) begin
                            r_valid[free_idx] <= 1'b1;
                        end
                    end
                end
                F_WAIT: begin
                    if (i_done.done) begin
                        r_state <= F_IDLE;
                        if (i_done.free) begin
                            r_valid[r_idx] <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_s_axis_tvalid) begin
            r_item.kind    <= srm_pkg::K_FULL;
            r_item.key     <= i_s_axis_tdata[63:0];
            r_item.node    <= i_s_axis_tdata[67:64];
            r_item.seqnum  <= i_s_axis_tdata[131:68];
            r_item.payload <= i_s_axis_tdata[195:132];
            r_item.found   <= i_s_axis_tuser[0];
            r_item.dir     <= i_s_axis_tuser[2:1];
        end
        if (r_state == F_MATCH) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_hit_vec[i]  <= r_valid[i] && (r_key[i] == r_item.key);
                r_free_vec[i] <= !r_valid[i];
            end
        end
        if (o_q_push) begin
            r_idx <= n_idx;
            if (job.kind == srm_pkg::K_NEW) begin
                r_key[free_idx] <= r_item.key;
            end
        end
    end

endmodule

// ===== rtl/srm_back.sv =====
// back: reads the entry's answer memory, merges, decides completion, drives results
// depends on srm_pkg

module srm_back #(
    parameter  int TABLE_ENTRIES = 16,
    parameter  int MAX_SHARDS    = 16,
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int QW = IW + $bits(srm_pkg::t_job)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srm_pkg::CNT_W-1:0]       i_cfg_data,
    input  logic [QW-1:0]                   i_q_data,
    input  logic                            i_q_empty,
    output logic                            o_q_pop,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [srm_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic [srm_pkg::OUT_USER_W-1:0]  o_m_axis_tuser,
    output srm_pkg::t_done                  o_done
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_MERGE,
        B_OUT
    } t_bstate;

    t_bstate                        r_state;
    srm_pkg::t_ans                  r_mem [TABLE_ENTRIES];
    srm_pkg::t_ans                  r_rd;
    srm_pkg::t_job                  r_job;
    logic [IW-1:0]                  r_idx;
    logic [srm_pkg::CNT_W-1:0]      r_num_shards;
    logic [srm_pkg::STATUS_W-1:0]   r_res_status;
    logic                           r_res_found;
    logic [srm_pkg::SEQ_W-1:0]      r_res_seq;
    logic [srm_pkg::PAY_W-1:0]      r_res_pay;
    logic                           r_res_free;
    logic                           r_ovalid;
    logic [srm_pkg::STATUS_W-1:0]   r_ostatus;
    logic                           r_ofound;
    logic [srm_pkg::KEY_W-1:0]      r_okey;
    logic [srm_pkg::SEQ_W-1:0]      r_oseq;
    logic [srm_pkg::PAY_W-1:0]      r_opay;
    srm_pkg::t_done                 r_done;

    srm_pkg::t_job                  q_job;
    logic [IW-1:0]                  q_idx;
    logic                           counted;
    logic [srm_pkg::NODE_SLOTS-1:0] nb;
    logic                           take;
    logic                           complete;
    logic                           out_load;
    srm_pkg::t_ans                  n_ent;

    assign q_job = srm_pkg::t_job'(i_q_data[$bits(srm_pkg::t_job)-1:0]);
    assign q_idx = i_q_data[QW-1:$bits(srm_pkg::t_job)];

    assign o_cfg_ready     = 1'b1;
    assign o_q_pop         = (r_state == B_IDLE) && !i_q_empty;
    assign out_load        = (r_state == B_OUT) && (!r_ovalid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_opay, r_oseq, r_okey};
    assign o_m_axis_tuser  = {r_ofound, r_ostatus};
    assign o_done          = r_done;

    // merge rule
    always_comb begin
        counted = (32'(r_job.node) < MAX_SHARDS);
        nb      = counted ? (srm_pkg::NODE_SLOTS'(1) << r_job.node) : '0;
        priority if (r_rd.found && !r_job.found) begin
            take = 1'b0;
        end else if (!r_rd.found && r_job.found) begin
            take = 1'b1;
        end else if (r_rd.dir == srm_pkg::DIR_PREV) begin
            take = (r_rd.seqnum < r_job.seqnum);
        end else begin
            take = (r_job.seqnum < r_rd.seqnum);
        end
        if (r_job.kind == srm_pkg::K_NEW) begin
            n_ent.found   = r_job.found;
            n_ent.seqnum  = r_job.seqnum;
            n_ent.dir     = r_job.dir;
            n_ent.payload = r_job.payload;
            n_ent.nodes   = nb;
            n_ent.cnt     = srm_pkg::CNT_W'(counted);
        end else begin
            n_ent = r_rd;
            if (take) begin
                n_ent.found   = r_job.found;
                n_ent.seqnum  = r_job.seqnum;
                n_ent.dir     = r_job.dir;
                n_ent.payload = r_job.payload;
            end
            n_ent.nodes = r_rd.nodes | nb;
            n_ent.cnt   = r_rd.cnt
                        + srm_pkg::CNT_W'(counted && !r_rd.nodes[r_job.node]);
        end
        complete = (n_ent.cnt == r_num_shards);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_num_shards <= srm_pkg::CNT_W'(1);
            r_ovalid     <= 1'b0;
            r_done       <= '0;
        end else begin
            r_done.done <= out_load && (r_job.kind != srm_pkg::K_FULL);
            r_done.free <= out_load && r_res_free;
            if (i_cfg_valid) begin
                r_num_shards <= i_cfg_data;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        unique case (q_job.kind)
                            srm_pkg::K_HIT:  r_state <= B_READ;
                            srm_pkg::K_NEW:  r_state <= B_MERGE;
                            default:         r_state <= B_OUT;
                        endcase
                    end
                end
                B_READ: begin
                    r_state <= B_MERGE;
                end
                B_MERGE: begin
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (out_load) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job        <= q_job;
            r_idx        <= q_idx;
            r_res_status <= srm_pkg::ST_FULL;
            r_res_found  <= 1'b0;
            r_res_seq    <= '0;
            r_res_pay    <= '0;
            r_res_free   <= 1'b0;
        end
        if (r_state == B_READ) begin
            r_rd <= r_mem[r_idx];
        end
        if (r_state == B_MERGE) begin
            r_mem[r_idx] <= n_ent;
            r_res_free   <= complete;
            if (complete) begin
                r_res_status <= srm_pkg::ST_DONE;
                r_res_found  <= n_ent.found;
                r_res_seq    <= n_ent.seqnum;
                r_res_pay    <= n_ent.payload;
            end else begin
                r_res_status <= srm_pkg::ST_PENDING;
            end
        end
        if (out_load) begin
            r_ostatus <= r_res_status;
            r_ofound  <= r_res_found;
            r_okey    <= r_job.key;
            r_oseq    <= r_res_seq;
            r_opay    <= r_res_pay;
        end
    end

endmodule

// ===== rtl/shard_result_merge_table_top.sv =====
// shard result merge table, top level: front matcher, job queue, merge back end
// an answer on a key hit reads the entry's answer memory before the merge; a new key skips
//   the read, and a dropped item skips read and merge
// the front takes a new answer only once the back has loaded the last one's result and
//   freed its entry if complete; dropped items do not wait on the back; a stalled result
//   output adds its stall
// reset: synchronous, active low; clears all entries and sets num_shards to 1
// depends on srm_pkg, srm_front, srm_queue, srm_back

module shard_result_merge_table_top #(
    parameter int TABLE_ENTRIES = 16,
    parameter int MAX_SHARDS    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srm_pkg::CNT_W-1:0]       i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // query_key[63:0], node_id[67:64], seqnum[131:68], payload[195:132], zero pad
    input  logic [srm_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // found[0], direction[2:1]
    input  logic [srm_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // out_key[63:0], out_seqnum[127:64], out_payload[191:128]
    output logic [srm_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // status[1:0], out_found[2]
    output logic [srm_pkg::OUT_USER_W-1:0]  o_m_axis_tuser
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int QW = IW + $bits(srm_pkg::t_job);

    logic           q_push;
    logic           q_pop;
    logic           q_empty;
    logic           q_full;
    logic [QW-1:0]  q_wdata;
    logic [QW-1:0]  q_rdata;
    srm_pkg::t_done done;

    srm_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_data        (q_wdata),
        .i_done          (done)
    );

    srm_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    srm_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_SHARDS    (MAX_SHARDS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_q_data        (q_rdata),
        .i_q_empty       (q_empty),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_done          (done)
    );

endmodule

// ===== tb/merge_checker.sv =====
`timescale 1ns / 1ps
// result checker for shard_result_merge_table_top: keeps its own open-query table,
// predicts one result per answer transfer and compares result transfers in order
// depends on srm_pkg

module merge_checker #(
    parameter int TABLE_ENTRIES = 16,
    parameter int MAX_SHARDS    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [srm_pkg::CNT_W-1:0]      i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    // query_key[63:0], node_id[67:64], seqnum[131:68], payload[195:132], zero pad
    input  logic [srm_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // found[0], direction[2:1]
    input  logic [srm_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // out_key[63:0], out_seqnum[127:64], out_payload[191:128]
    input  logic [srm_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    // status[1:0], out_found[2]
    input  logic [srm_pkg::OUT_USER_W-1:0] i_m_axis_tuser,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic [srm_pkg::STATUS_W-1:0] status;
        logic [srm_pkg::KEY_W-1:0]    key;
        logic                         found;
        logic [srm_pkg::SEQ_W-1:0]    seqnum;
        logic [srm_pkg::PAY_W-1:0]    payload;
    } t_merged;

    logic                         open_valid [TABLE_ENTRIES];
    logic [srm_pkg::KEY_W-1:0]    open_key   [TABLE_ENTRIES];
    logic [MAX_SHARDS-1:0]        open_nodes [TABLE_ENTRIES];
    logic                         open_found [TABLE_ENTRIES];
    logic [srm_pkg::SEQ_W-1:0]    open_seq   [TABLE_ENTRIES];
    logic [srm_pkg::DIR_W-1:0]    open_dir   [TABLE_ENTRIES];
    logic [srm_pkg::PAY_W-1:0]    open_pay   [TABLE_ENTRIES];
    logic [srm_pkg::CNT_W-1:0]    shard_goal;
    t_merged                      expected_merges [$];

    task automatic predict_merge(
        input  logic [srm_pkg::KEY_W-1:0]  key,
        input  logic [srm_pkg::NODE_W-1:0] node,
        input  logic                       found,
        input  logic [srm_pkg::SEQ_W-1:0]  seq,
        input  logic [srm_pkg::DIR_W-1:0]  dir,
        input  logic [srm_pkg::PAY_W-1:0]  pay,
        output t_merged                    res
    );
        int                    hit;
        int                    free_idx;
        logic                  take;
        logic [MAX_SHARDS-1:0] node_mask;
        hit = -1;
        free_idx = -1;
        node_mask = '0;
        if (node < MAX_SHARDS) node_mask[node] = 1'b1;
        res = '0;
        res.status = srm_pkg::ST_PENDING;
        res.key = key;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (open_valid[i]) begin
                if (hit < 0 && open_key[i] == key) hit = i;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (hit < 0) begin
            if (free_idx < 0) begin
                res.status = srm_pkg::ST_FULL;
                return;
            end
            hit = free_idx;
            open_valid[hit] = 1'b1;
            open_key[hit]   = key;
            open_nodes[hit] = node_mask;
            open_found[hit] = found;
            open_seq[hit]   = seq;
            open_dir[hit]   = dir;
            open_pay[hit]   = pay;
        end else begin
            if (open_found[hit] && !found)
                take = 1'b0;
            else if (!open_found[hit] && found)
                take = 1'b1;
            else if (open_dir[hit] == srm_pkg::DIR_PREV)
                take = open_seq[hit] < seq;
            else
                take = seq < open_seq[hit];
            if (take) begin
                open_found[hit] = found;
                open_seq[hit]   = seq;
                open_dir[hit]   = dir;
                open_pay[hit]   = pay;
            end
            open_nodes[hit] |= node_mask;
        end
        if ($countones(open_nodes[hit]) == shard_goal) begin
            res.status  = srm_pkg::ST_DONE;
            res.found   = open_found[hit];
            res.seqnum  = open_seq[hit];
            res.payload = open_pay[hit];
            open_valid[hit] = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_merged want;
        t_merged got;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) open_valid[i] = 1'b0;
            shard_goal = srm_pkg::CNT_W'(1);
            expected_merges.delete();
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) shard_goal = i_cfg_data;
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_merge(i_s_axis_tdata[63:0], i_s_axis_tdata[67:64],
                              i_s_axis_tuser[0], i_s_axis_tdata[131:68],
                              i_s_axis_tuser[2:1], i_s_axis_tdata[195:132], want);
                expected_merges.push_back(want);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.status  = i_m_axis_tuser[1:0];
                got.found   = i_m_axis_tuser[2];
                got.key     = i_m_axis_tdata[63:0];
                got.seqnum  = i_m_axis_tdata[127:64];
                got.payload = i_m_axis_tdata[191:128];
                if (expected_merges.size() == 0) begin
                    $error("result transfer with no answer waiting, key %h", got.key);
                    o_fail_count++;
                end else begin
                    want = expected_merges.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.key !== want.key) begin
                        $error("out_key: expected %h, actual %h", want.key, got.key);
                        o_fail_count++;
                    end
                    if (got.found !== want.found) begin
                        $error("out_found: expected %0d, actual %0d", want.found, got.found);
                        o_fail_count++;
                    end
                    if (got.seqnum !== want.seqnum) begin
                        $error("out_seqnum: expected %h, actual %h", want.seqnum, got.seqnum);
                        o_fail_count++;
                    end
                    if (got.payload !== want.payload) begin
                        $error("out_payload: expected %h, actual %h",
                               want.payload, got.payload);
                        o_fail_count++;
                    end
                end
            end
            o_pending = expected_merges.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// top of the testbench for shard_result_merge_table_top: clock, reset, answer and
// shard-count stimulus with random gaps and stalls; checking is done by merge_checker
// depends on srm_pkg, merge_checker and the block's rtl

module testbench;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [srm_pkg::CNT_W-1:0]      cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [srm_pkg::IN_DATA_W-1:0]  s_tdata;
    logic [srm_pkg::IN_USER_W-1:0]  s_tuser;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [srm_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [srm_pkg::OUT_USER_W-1:0] m_tuser;
    int                             fail_count;
    int                             pending;
    int                             stall_left = 0;
    bit                             quiet = 1'b0;

    shard_result_merge_table_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    merge_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // result side stalls
    always @(negedge clk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
            stall_left = pick_gap();
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_answer(
        input logic [srm_pkg::KEY_W-1:0]  key,
        input logic [srm_pkg::NODE_W-1:0] node,
        input logic                       found,
        input logic [srm_pkg::SEQ_W-1:0]  seq,
        input logic [srm_pkg::DIR_W-1:0]  dir,
        input logic [srm_pkg::PAY_W-1:0]  pay
    );
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {4'b0, pay, seq, node, key};
        s_tuser  = {dir, found};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic push_random(
        input logic [srm_pkg::KEY_W-1:0]  key,
        input logic [srm_pkg::NODE_W-1:0] node
    );
        logic [srm_pkg::SEQ_W-1:0] seq;
        seq = ($urandom_range(0, 9) < 3) ? 64'($urandom_range(0, 3)) : rand64();
        push_answer(key, node, 1'($urandom), seq, 2'($urandom_range(0, 3)), rand64());
    endtask

    task automatic write_shards(input logic [srm_pkg::CNT_W-1:0] n);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (12) @(negedge clk);
        cfg_data  = n;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // two shards answering one query, shard count 2
    task automatic merge_pair(
        input logic f1, input logic [srm_pkg::SEQ_W-1:0] s1, input logic [srm_pkg::DIR_W-1:0] d1,
        input logic f2, input logic [srm_pkg::SEQ_W-1:0] s2, input logic [srm_pkg::DIR_W-1:0] d2
    );
        logic [srm_pkg::KEY_W-1:0] key;
        key = rand64();
        push_answer(key, 4'd1, f1, s1, d1, rand64());
        push_answer(key, 4'd14, f2, s2, d2, rand64());
    endtask

    task automatic run_phase(input int goal, input int n_items);
        logic [srm_pkg::KEY_W-1:0]  a_key   [16];
        logic [srm_pkg::NODE_W-1:0] a_order [16][16];
        int                         a_sent  [16];
        int                         a_n;
        int                         q;
        int                         r;
        int                         k;
        logic [srm_pkg::NODE_W-1:0] t;
        a_n = 0;
        write_shards(srm_pkg::CNT_W'(goal));
        for (int it = 0; it < n_items; it++) begin
            r = $urandom_range(0, 99);
            // every open query holds an entry, so a fresh key now gets dropped
            if (a_n == 16 && r < 6) begin
                push_random(rand64(), srm_pkg::NODE_W'($urandom_range(0, 15)));
                continue;
            end
            if (a_n == 0 || (a_n < 16 && r < 30)) begin
                q = a_n;
                a_key[q] = rand64();
                for (int j = 0; j < 16; j++) a_order[q][j] = srm_pkg::NODE_W'(j);
                for (int j = 15; j > 0; j--) begin
                    k = $urandom_range(0, j);
                    t = a_order[q][j];
                    a_order[q][j] = a_order[q][k];
                    a_order[q][k] = t;
                end
                a_sent[q] = 0;
                a_n++;
            end else begin
                q = $urandom_range(0, a_n - 1);
            end
            if (r >= 30 && r < 40 && a_sent[q] > 0) begin
                push_random(a_key[q], a_order[q][$urandom_range(0, a_sent[q] - 1)]);
            end else begin
                push_random(a_key[q], a_order[q][a_sent[q]]);
                a_sent[q]++;
                if (a_sent[q] == goal) begin
                    a_key[q]   = a_key[a_n - 1];
                    a_order[q] = a_order[a_n - 1];
                    a_sent[q]  = a_sent[a_n - 1];
                    a_n--;
                end
            end
        end
        // finish every query still open
        while (a_n > 0) begin
            q = a_n - 1;
            while (a_sent[q] < goal) begin
                push_random(a_key[q], a_order[q][a_sent[q]]);
                a_sent[q]++;
            end
            a_n--;
        end
    endtask

    initial begin
        logic [srm_pkg::KEY_W-1:0] stuck [18];
        logic [srm_pkg::KEY_W-1:0] key;
        int                        goals [12];
        goals = '{1, 16, 2, 4, 3, 16, 7, 1, 12, 2, 5, 16};
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // shard count 1 after reset: every answer completes at once
        push_answer('0, 4'd0, 1'b0, '0, 2'd0, '0);
        push_answer('1, 4'd15, 1'b1, '1, 2'd2, '1);
        push_answer(rand64(), 4'd5, 1'b1, 64'h8000_0000_0000_0000, 2'd3, rand64());
        push_answer(rand64(), 4'd10, 1'b0, rand64(), 2'd1, rand64());

        write_shards(srm_pkg::CNT_W'(2));
        merge_pair(1'b1, 64'd100, 2'd0, 1'b0, 64'd500, 2'd0);
        merge_pair(1'b0, 64'd500, 2'd1, 1'b1, 64'd100, 2'd1);
        merge_pair(1'b1, 64'd10, 2'd0, 1'b1, 64'd20, 2'd1);
        merge_pair(1'b1, 64'd20, 2'd0, 1'b1, 64'd10, 2'd0);
        merge_pair(1'b0, 64'd30, 2'd1, 1'b0, 64'd5, 2'd2);
        merge_pair(1'b1, 64'd5, 2'd2, 1'b1, '1, 2'd0);
        merge_pair(1'b1, 64'd50, 2'd3, 1'b1, 64'd40, 2'd0);
        merge_pair(1'b1, 64'd7, 2'd0, 1'b1, 64'd7, 2'd1);
        // repeated shard merges but does not count
        key = rand64();
        push_answer(key, 4'd3, 1'b0, 64'd9, 2'd1, rand64());
        push_answer(key, 4'd3, 1'b1, 64'd4, 2'd1, rand64());
        push_answer(key, 4'd7, 1'b1, 64'd2, 2'd1, rand64());

        for (int p = 0; p < 12; p++) begin
            quiet = (p == 3 || p == 8);
            run_phase(goals[p], 100);
        end
        quiet = 1'b0;

        // unreachable shard counts: entries stay occupied, so this comes last
        write_shards(srm_pkg::CNT_W'(0));
        for (int i = 0; i < 18; i++) begin
            stuck[i] = rand64();
            push_random(stuck[i], srm_pkg::NODE_W'($urandom_range(0, 15)));
        end
        for (int i = 0; i < 3; i++)
            push_random(stuck[$urandom_range(0, 15)], srm_pkg::NODE_W'($urandom_range(0, 15)));
        write_shards('1);
        push_random(stuck[0], 4'd15);
        push_random(stuck[15], 4'd0);
        push_random(rand64(), 4'd8);
        push_random(stuck[17], 4'd2);
        s_tvalid = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/srm_pkg.sv
rtl/srm_queue.sv
rtl/srm_front.sv
rtl/srm_back.sv
rtl/shard_result_merge_table_top.sv
tb/merge_checker.sv
tb/testbench.sv
